// ----- hw/rtl/brsc_pkg.sv -----
// brsc_pkg: shared types, constants and codes for the baseline relearn stability check
`timescale 1ns / 1ps
`default_nettype none
package brsc_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int MAX_WINDOW_DEF  = 1024;
    localparam int MEAN_BITS       = 24;
    localparam int DEV_BITS        = 23;
    localparam int WIN_BITS        = 11;
    localparam int FRAC_BITS       = 16;
    localparam int CFG_DATA_BITS   = 23;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [WIN_BITS-1:0]  WINDOW_RESET    = 11'd64;
    localparam logic [FRAC_BITS-1:0] STAB_FRAC_RESET = 16'd3277;
    localparam logic [FRAC_BITS-1:0] FLOOR_FRAC_RESET = 16'd655;
    localparam logic [DEV_BITS-1:0]  FLOOR_ABS_RESET = 23'd256;
    localparam logic [DEV_BITS-1:0]  DEV_SAT         = 23'h7FFFFF;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WINDOW_COUNT = 2'd0,
        CFG_STAB_FRAC    = 2'd1,
        CFG_FLOOR_FRAC   = 2'd2,
        CFG_FLOOR_ABS    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'd0,
        ST_ACC  = 4'd1,
        ST_TEST = 4'd2,
        ST_MEAN = 4'd3,
        ST_MULA = 4'd4,
        ST_MULB = 4'd5,
        ST_NN   = 4'd6,
        ST_VAR  = 4'd7,
        ST_SQRT = 4'd8,
        ST_LIM  = 4'd9,
        ST_DEC  = 4'd10
    } state_t;

    typedef struct packed {
        logic                   start;
        alu_op_t                op;
    } alu_req_t;

    typedef struct packed {
        logic                   busy;
        logic                   done;
    } alu_rsp_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          out_of_band;
    } in_word_t;

    typedef struct packed {
        logic                         accepted;
        logic signed [MEAN_BITS-1:0]  new_mean;
        logic        [DEV_BITS-1:0]   new_stddev;
    } out_word_t;

endpackage
`default_nettype wire

// ----- hw/rtl/brsc_alu.sv -----
// brsc_alu: bit-serial shared multiply, divide and square root unit
`timescale 1ns / 1ps
`default_nettype none
module brsc_alu #(
    parameter int WW = 68
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire brsc_pkg::alu_req_t req,
    input  wire logic [WW-1:0]     opa,
    input  wire logic [WW-1:0]     opb,
    output brsc_pkg::alu_rsp_t     rsp,
    output logic      [WW-1:0]     result
);
    import brsc_pkg::*;

    localparam int CNW = $clog2(WW + 1);

    logic [WW-1:0]  acc_reg, acc_next;
    logic [WW-1:0]  sa_reg, sa_next;
    logic [WW-1:0]  sb_reg, sb_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    alu_op_t        op_reg, op_next;

    logic [WW:0]    div_trial;
    logic [WW+1:0]  sq_rem;
    logic [WW+1:0]  sq_try;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
        acc_reg <= acc_next;
        sa_reg  <= sa_next;
        sb_reg  <= sb_next;
    end

    always_comb begin
        acc_next  = acc_reg;
        sa_next   = sa_reg;
        sb_next   = sb_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        div_trial = {acc_reg, sa_reg[WW-1]} - {1'b0, sb_reg};
        sq_rem    = {acc_reg, sa_reg[WW-1:WW-2]};
        sq_try    = {sb_reg, 2'b01};
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            acc_next  = '0;
            sa_next   = opa;
            sb_next   = (req.op == OP_SQRT) ? '0 : opb;
            cnt_next  = (req.op == OP_SQRT) ? CNW'(WW / 2) : CNW'(WW);
        end else if (busy_reg) begin
            unique case (op_reg)
                OP_MUL: begin
                    if (sb_reg[0]) begin
                        acc_next = acc_reg + sa_reg;
                    end
                    sa_next = {sa_reg[WW-2:0], 1'b0};
                    sb_next = {1'b0, sb_reg[WW-1:1]};
                end
                OP_DIV: begin
                    if (!div_trial[WW]) begin
                        acc_next = div_trial[WW-1:0];
                    end else begin
                        acc_next = {acc_reg[WW-2:0], sa_reg[WW-1]};
                    end
                    sa_next = {sa_reg[WW-2:0], ~div_trial[WW]};
                end
                OP_SQRT: begin
                    if (sq_rem >= sq_try) begin
                        acc_next = WW'(sq_rem - sq_try);
                        sb_next  = {sb_reg[WW-2:0], 1'b1};
                    end else begin
                        acc_next = sq_rem[WW-1:0];
                        sb_next  = {sb_reg[WW-2:0], 1'b0};
                    end
                    sa_next = {sa_reg[WW-3:0], 2'b00};
                end
                default: begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (op_reg)
            OP_MUL:  result = acc_reg;
            OP_DIV:  result = sa_reg;
            OP_SQRT: result = sb_reg;
            default: result = acc_reg;
        endcase
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/baseline_relearn_stability_check_top.sv -----
// baseline_relearn_stability_check_top: run accumulation and window-end stability sequencer
//
//   channel   dir  handshake            word
//   s_        in   s_valid / s_ready    sample, out_of_band
//   m_        out  m_valid / m_ready    accepted, new_mean, new_stddev
//   cfg_      in   cfg_wr_en            cfg_index, cfg_wr_data
//
// a sample that does not close a window has its result registered out of ST_ACC (in band)
// or ST_TEST (out of band); the next word is taken the cycle after the result is taken
// a window-end sample then runs ST_MEAN through ST_DEC, waiting in each alu state on the
// bit-serial shared alu (WW = 68 by default) doing mean divide, three products, variance
// divide and square root one after another
// s_ready is low while a word is being worked on or a result waits on m_
// aresetn is synchronous; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
module baseline_relearn_stability_check_top #(
    parameter int MAX_WINDOW = brsc_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire brsc_pkg::in_word_t                    s_data,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output brsc_pkg::out_word_t                        m_data,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [brsc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [brsc_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data
);
    import brsc_pkg::*;

    localparam int SB  = SAMPLE_BITS;
    localparam int CW  = $clog2(MAX_WINDOW + 1);
    localparam int SW  = SB + CW;
    localparam int QW  = 2 * SB + CW - 2;
    localparam int WW  = ((CW + QW + 16 + 1) / 2) * 2;
    localparam int DVW = WW / 2;
    localparam int AMW = SB + 8;
    localparam int MW  = AMW + FRAC_BITS;
    localparam int CMW = DVW + AMW;
    localparam int XW  = (CW > WIN_BITS) ? CW : WIN_BITS;

    state_t                state_reg, state_next;
    logic                  run_active_reg, run_active_next;
    logic [CW-1:0]         run_count_reg, run_count_next;
    logic signed [SW-1:0]  run_sum_reg, run_sum_next;
    logic [QW-1:0]         run_sq_reg, run_sq_next;
    in_word_t              in_reg, in_next;
    logic [SW-1:0]         asum_reg, asum_next;
    logic                  neg_reg, neg_next;
    logic [AMW-1:0]        amean_reg, amean_next;
    logic [WW-1:0]         a_reg, a_next;
    logic [WW-1:0]         b_reg, b_next;
    logic [DVW-1:0]        dev_reg, dev_next;
    logic [AMW-1:0]        lim_reg, lim_next;
    out_word_t             out_reg, out_next;
    logic                  m_valid_reg, m_valid_next;

    logic [WIN_BITS-1:0]   win_cfg_reg;
    logic [FRAC_BITS-1:0]  stab_frac_reg;
    logic [FRAC_BITS-1:0]  floor_frac_reg;
    logic [DEV_BITS-1:0]   floor_abs_reg;

    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;
    logic [WW-1:0]         alu_opa, alu_opb, alu_res;

    logic [XW-1:0]         win_x;
    logic [CW-1:0]         win;
    logic [SB-1:0]         mag;
    logic [2*SB-1:0]       mag_sq;
    logic signed [SW-1:0]  sum_base;
    logic [QW-1:0]         sq_base;
    logic [CW-1:0]         cnt_base;
    logic [SW-1:0]         asum_c;
    logic [WW-1:0]         d_c;
    logic [MW-1:0]         prod_c;
    logic [AMW-1:0]        frac_c;
    logic [AMW-1:0]        floor_ext;
    logic [AMW-1:0]        flo_c;
    logic [CMW-1:0]        dev_ext;
    logic [CMW-1:0]        std_c;
    logic [AMW-1:0]        mean_sel;

    brsc_alu #(.WW(WW)) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa     (alu_opa),
        .opb     (alu_opb),
        .rsp     (alu_rsp),
        .result  (alu_res)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_cfg_reg    <= WINDOW_RESET;
            stab_frac_reg  <= STAB_FRAC_RESET;
            floor_frac_reg <= FLOOR_FRAC_RESET;
            floor_abs_reg  <= FLOOR_ABS_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WINDOW_COUNT: win_cfg_reg    <= cfg_wr_data[WIN_BITS-1:0];
                CFG_STAB_FRAC:    stab_frac_reg  <= cfg_wr_data[FRAC_BITS-1:0];
                CFG_FLOOR_FRAC:   floor_frac_reg <= cfg_wr_data[FRAC_BITS-1:0];
                CFG_FLOOR_ABS:    floor_abs_reg  <= cfg_wr_data[DEV_BITS-1:0];
                default:          win_cfg_reg    <= win_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            run_active_reg <= 1'b0;
            run_count_reg  <= '0;
            run_sum_reg    <= '0;
            run_sq_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            run_active_reg <= run_active_next;
            run_count_reg  <= run_count_next;
            run_sum_reg    <= run_sum_next;
            run_sq_reg     <= run_sq_next;
            m_valid_reg    <= m_valid_next;
        end
        in_reg    <= in_next;
        asum_reg  <= asum_next;
        neg_reg   <= neg_next;
        amean_reg <= amean_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        dev_reg   <= dev_next;
        lim_reg   <= lim_next;
        out_reg   <= out_next;
    end

    // effective window, clamped to [2, MAX_WINDOW]
    always_comb begin
        win_x = XW'(win_cfg_reg);
        if (win_x < XW'(2)) begin
            win = CW'(2);
        end else if (win_x > XW'(MAX_WINDOW)) begin
            win = CW'(MAX_WINDOW);
        end else begin
            win = win_x[CW-1:0];
        end
    end

    always_comb begin
        mag       = in_reg.sample[SB-1] ? (~in_reg.sample + SB'(1)) : in_reg.sample;
        mag_sq    = mag * mag;
        sum_base  = run_active_reg ? run_sum_reg : '0;
        sq_base   = run_active_reg ? run_sq_reg : '0;
        cnt_base  = run_active_reg ? run_count_reg : '0;
        asum_c    = run_sum_reg[SW-1] ? SW'(-run_sum_reg) : run_sum_reg;
        d_c       = (a_reg > b_reg) ? (a_reg - b_reg) : '0;
        mean_sel  = neg_reg ? (~amean_reg + AMW'(1)) : amean_reg;
        floor_ext = AMW'(floor_abs_reg);
        prod_c    = (state_reg == ST_LIM) ? (stab_frac_reg * amean_reg)
                                          : (floor_frac_reg * amean_reg);
        frac_c    = prod_c[MW-1:FRAC_BITS];
        flo_c     = (frac_c > floor_ext) ? frac_c : floor_ext;
        dev_ext   = CMW'(dev_reg);
        std_c     = (dev_ext < CMW'(flo_c)) ? CMW'(flo_c) : dev_ext;
    end

    always_comb begin
        state_next      = state_reg;
        run_active_next = run_active_reg;
        run_count_next  = run_count_reg;
        run_sum_next    = run_sum_reg;
        run_sq_next     = run_sq_reg;
        in_next         = in_reg;
        asum_next       = asum_reg;
        neg_next        = neg_reg;
        amean_next      = amean_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        dev_next        = dev_reg;
        lim_next        = lim_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        alu_req.start   = 1'b0;
        alu_req.op      = OP_MUL;
        alu_opa         = '0;
        alu_opb         = '0;
        s_ready         = (state_reg == ST_IDLE) && !m_valid_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    in_next    = s_data;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (!in_reg.out_of_band) begin
                    run_active_next = 1'b0;
                    run_count_next  = '0;
                    run_sum_next    = '0;
                    run_sq_next     = '0;
                    out_next        = '0;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end else begin
                    run_active_next = 1'b1;
                    run_sum_next    = sum_base + {{(SW-SB){in_reg.sample[SB-1]}}, in_reg.sample};
                    run_sq_next     = sq_base + QW'(mag_sq);
                    run_count_next  = cnt_base + CW'(1);
                    state_next      = ST_TEST;
                end
            end
            ST_TEST: begin
                if (run_count_reg < win) begin
                    out_next     = '0;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end else begin
                    asum_next     = asum_c;
                    neg_next      = run_sum_reg[SW-1];
                    alu_req.start = 1'b1;
                    alu_req.op    = OP_DIV;
                    alu_opa       = WW'({asum_c, 8'h00}) + WW'(run_count_reg >> 1);
                    alu_opb       = WW'(run_count_reg);
                    state_next    = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (alu_rsp.done) begin
                    amean_next    = alu_res[AMW-1:0];
                    alu_req.start = 1'b1;
                    alu_req.op    = OP_MUL;
                    alu_opa       = WW'(run_sq_reg);
                    alu_opb       = WW'(run_count_reg);
                    state_next    = ST_MULA;
                end
            end
            ST_MULA: begin
                if (alu_rsp.done) begin
                    a_next        = alu_res;
                    alu_req.start = 1'b1;
                    alu_req.op    = OP_MUL;
                    alu_opa       = WW'(asum_reg);
                    alu_opb       = WW'(asum_reg);
                    state_next    = ST_MULB;
                end
            end
            ST_MULB: begin
                if (alu_rsp.done) begin
                    b_next        = alu_res;
                    alu_req.start = 1'b1;
                    alu_req.op    = OP_MUL;
                    alu_opa       = WW'(run_count_reg);
                    alu_opb       = WW'(run_count_reg);
                    state_next    = ST_NN;
                end
            end
            ST_NN: begin
                if (alu_rsp.done) begin
                    alu_req.start = 1'b1;
                    alu_req.op    = OP_DIV;
                    alu_opa       = {d_c[WW-17:0], 16'h0000};
                    alu_opb       = alu_res;
                    state_next    = ST_VAR;
                end
            end
            ST_VAR: begin
                if (alu_rsp.done) begin
                    alu_req.start = 1'b1;
                    alu_req.op    = OP_SQRT;
                    alu_opa       = alu_res;
                    state_next    = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (alu_rsp.done) begin
                    dev_next   = alu_res[DVW-1:0];
                    state_next = ST_LIM;
                end
            end
            ST_LIM: begin
                lim_next   = (frac_c < floor_ext) ? floor_ext : frac_c;
                state_next = ST_DEC;
            end
            ST_DEC: begin
                run_count_next = '0;
                run_sum_next   = '0;
                run_sq_next    = '0;
                m_valid_next   = 1'b1;
                state_next     = ST_IDLE;
                if (dev_ext > CMW'(lim_reg)) begin
                    out_next = '0;
                end else begin
                    run_active_next    = 1'b0;
                    out_next.accepted  = 1'b1;
                    out_next.new_mean  = MEAN_BITS'(mean_sel);
                    out_next.new_stddev = (std_c > CMW'(DEV_SAT)) ? DEV_SAT
                                                                  : std_c[DEV_BITS-1:0];
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

// ----- tb/tb_baseline_relearn_stability_check_top.sv -----
// testbench for the baseline relearn stability check: directed table and random runs
`timescale 1ns / 1ps
`default_nettype none
module tb_baseline_relearn_stability_check_top;
    import brsc_pkg::*;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_word_t s_data;
    logic m_valid;
    logic m_ready;
    out_word_t m_data;
    logic cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data;

    baseline_relearn_stability_check_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
    );

    // predictor state
    logic [WIN_BITS-1:0]  win_reg;
    logic [FRAC_BITS-1:0] stab_reg;
    logic [FRAC_BITS-1:0] flr_frac_reg;
    logic [DEV_BITS-1:0]  flr_abs_reg;
    bit                   active;
    longint unsigned      cnt;
    longint               acc_sum;
    longint unsigned      acc_sq;

    out_word_t baseline_q[$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int run_kind;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #400ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int abs_i(int x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic out_word_t predict_baseline(in_word_t w);
        out_word_t o;
        longint unsigned wn, n, asum, amean, a, b, d, nn, v, dev, lim, rel, flo, mag;
        longint s;
        bit neg;
        o = '0;
        wn = win_reg;
        if (wn < 2) wn = 2;
        if (wn > MAX_WINDOW_DEF) wn = MAX_WINDOW_DEF;
        if (!w.out_of_band) begin
            active = 0; cnt = 0; acc_sum = 0; acc_sq = 0;
            return o;
        end
        if (!active) begin
            active = 1; cnt = 0; acc_sum = 0; acc_sq = 0;
        end
        s = longint'(w.sample);
        mag = (s < 0) ? -s : s;
        acc_sum += s;
        acc_sq += mag * mag;
        cnt++;
        if (cnt < wn) return o;
        n = cnt;
        neg = acc_sum < 0;
        asum = neg ? -acc_sum : acc_sum;
        amean = (asum * 256 + n / 2) / n;
        a = n * acc_sq;
        b = asum * asum;
        d = (a > b) ? a - b : 0;
        nn = n * n;
        v = (d / nn) * 65536 + ((d % nn) * 65536) / nn;
        dev = int_sqrt(v);
        lim = (longint'(stab_reg) * amean) >> 16;
        if (lim < flr_abs_reg) lim = flr_abs_reg;
        if (dev > lim) begin
            cnt = 0; acc_sum = 0; acc_sq = 0;
            return o;
        end
        rel = (longint'(flr_frac_reg) * amean) >> 16;
        flo = (rel > flr_abs_reg) ? rel : flr_abs_reg;
        if (dev < flo) dev = flo;
        if (dev > 8388607) dev = 8388607;
        o.accepted = 1'b1;
        o.new_mean = MEAN_BITS'(neg ? -amean : amean);
        o.new_stddev = DEV_BITS'(dev);
        active = 0; cnt = 0; acc_sum = 0; acc_sq = 0;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // result side
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (baseline_q.size() == 0) begin
                report_mismatch("unexpected word", m_data.accepted, -1);
            end else begin
                out_word_t e;
                e = baseline_q.pop_front();
                if (m_data.accepted !== e.accepted)
                    report_mismatch("accepted", m_data.accepted, e.accepted);
                if (m_data.new_mean !== e.new_mean)
                    report_mismatch("new_mean", m_data.new_mean, e.new_mean);
                if (m_data.new_stddev !== e.new_stddev)
                    report_mismatch("new_stddev", m_data.new_stddev, e.new_stddev);
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(cfg_index_t idx, int unsigned val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= CFG_DATA_BITS'(val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_WINDOW_COUNT: win_reg = WIN_BITS'(val);
            CFG_STAB_FRAC:    stab_reg = FRAC_BITS'(val);
            CFG_FLOOR_FRAC:   flr_frac_reg = FRAC_BITS'(val);
            CFG_FLOOR_ABS:    flr_abs_reg = DEV_BITS'(val);
            default:          win_reg = win_reg;
        endcase
    endtask

    // called at a falling edge; leaves valid high on return
    task automatic send_word(in_word_t w, bit chk, out_word_t want);
        out_word_t p;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = predict_baseline(w);
        if (chk && p !== want) report_mismatch("table row", p.new_mean, want.new_mean);
        baseline_q.push_back(p);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (baseline_q.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
    endtask

    function automatic in_word_t rand_word(int spread, int centre, int pct_oob);
        in_word_t w;
        w.out_of_band = ($urandom_range(99) < pct_oob);
        w.sample = SAMPLE_BITS'(centre + $signed($urandom_range(2 * spread)) - spread);
        return w;
    endfunction

    typedef struct {
        logic [SAMPLE_BITS-1:0] smp;
        logic                   oob;
        bit                     chk;
        out_word_t              want;
    } dir_row_t;

    dir_row_t dir_tbl[$];

    initial begin
        in_word_t w;
        int centre, spread, nwin, ph;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        win_reg = WINDOW_RESET;
        stab_reg = STAB_FRAC_RESET;
        flr_frac_reg = FLOOR_FRAC_RESET;
        flr_abs_reg = FLOOR_ABS_RESET;
        active = 0; cnt = 0; acc_sum = 0; acc_sq = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // window of two, constant extremes give exact baselines
        write_reg(CFG_WINDOW_COUNT, 0);
        dir_tbl = '{
            '{16'h0000, 1'b0, 1, '{1'b0, 24'sd0, 23'd0}},
            '{16'h7FFF, 1'b1, 1, '{1'b0, 24'sd0, 23'd0}},
            '{16'h7FFF, 1'b1, 1, '{1'b1, 24'sh7FFF00, 23'd83837}},
            '{16'h8000, 1'b1, 1, '{1'b0, 24'sd0, 23'd0}},
            '{16'h8000, 1'b1, 1, '{1'b1, 24'sh800000, 23'd83840}},
            '{16'h0000, 1'b1, 1, '{1'b0, 24'sd0, 23'd0}},
            '{16'h0000, 1'b1, 1, '{1'b1, 24'sd0, 23'd256}},
            '{16'h7FFF, 1'b1, 0, '{1'b0, 24'sd0, 23'd0}},
            '{16'h8000, 1'b1, 0, '{1'b0, 24'sd0, 23'd0}},
            '{16'h1234, 1'b1, 0, '{1'b0, 24'sd0, 23'd0}},
            '{16'h5555, 1'b0, 1, '{1'b0, 24'sd0, 23'd0}},
            '{16'hAAAA, 1'b1, 0, '{1'b0, 24'sd0, 23'd0}},
            '{16'hAAAB, 1'b1, 0, '{1'b0, 24'sd0, 23'd0}},
            '{16'hFFFF, 1'b1, 0, '{1'b0, 24'sd0, 23'd0}},
            '{16'h0001, 1'b1, 0, '{1'b0, 24'sd0, 23'd0}}
        };
        foreach (dir_tbl[i]) begin
            w.sample = dir_tbl[i].smp;
            w.out_of_band = dir_tbl[i].oob;
            send_word(w, dir_tbl[i].chk, dir_tbl[i].want);
        end
        drain_results();
        // window above the maximum, lowered mid run
        write_reg(CFG_WINDOW_COUNT, 2047);
        write_reg(CFG_FLOOR_ABS, 0);
        for (int i = 0; i < 6; i++) begin
            w.sample = SAMPLE_BITS'(100 + i); w.out_of_band = 1'b1;
            send_word(w, 0, '0);
        end
        drain_results();
        write_reg(CFG_WINDOW_COUNT, 3);
        w.sample = 16'sd101; w.out_of_band = 1'b1;
        send_word(w, 0, '0);
        drain_results();

        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            nwin = (ph == 7) ? 64 : ((ph == 4) ? 2 : $urandom_range(12, 2));
            write_reg(CFG_WINDOW_COUNT, nwin);
            write_reg(CFG_STAB_FRAC, (ph == 5) ? 0 : ((ph == 6) ? 65535
                                     : $urandom_range(65535)));
            write_reg(CFG_FLOOR_FRAC, (ph == 5) ? 65535 : $urandom_range(65535));
            write_reg(CFG_FLOOR_ABS, (ph == 6) ? 8388607 : ((ph == 2) ? 1
                                     : $urandom_range(4000)));
            if (ph == 2) hold_cycles = 300;
            for (int i = 0; i < ((ph == 7) ? 240 : 120); ) begin
                run_kind = $urandom_range(9);
                centre = $signed($urandom_range(65535)) - 32768;
                spread = (run_kind < 6) ? $urandom_range(abs_i(centre) / 20 + 1)
                                        : $urandom_range(32767);
                for (int k = 0; k < nwin + 2 && i < ((ph == 7) ? 240 : 120); k++) begin
                    w = rand_word(spread, centre, (run_kind < 8) ? 97 : 60);
                    if (run_kind == 9) w.sample = SAMPLE_BITS'($urandom_range(65535));
                    send_word(w, 0, '0);
                    i++;
                end
                if (ph == 3 && i > 60 && i < 72) drain_results();
            end
            drain_results();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
